@@ hw/rtl/tsv_to_csv_field_quoter_core_macros.svh @@
// Assertion macros for the field quoter RTL; the datapath includes them.
`ifndef TSV_TO_CSV_FIELD_QUOTER_CORE_MACROS_SVH
`define TSV_TO_CSV_FIELD_QUOTER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante; uses i_clk and i_rst_n of the module.
`define TCQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tcq_pkg.sv @@
// Shared constants, codes and controller/datapath link types of the field quoter.
`default_nettype none

package tcq_pkg;

    localparam int unsigned CHAR_W        = 21;
    localparam int unsigned FIELD_BUF_DEF = 16;

    localparam logic [CHAR_W-1:0] CH_QUOTE = CHAR_W'(32'h22);
    localparam logic [CHAR_W-1:0] CH_COMMA = CHAR_W'(32'h2C);
    localparam logic [CHAR_W-1:0] CH_CR    = CHAR_W'(32'h0D);
    localparam logic [CHAR_W-1:0] CH_LF    = CHAR_W'(32'h0A);
    localparam logic [CHAR_W-1:0] CH_TAB   = CHAR_W'(32'h09);
    localparam logic [CHAR_W-1:0] CH_BSL   = CHAR_W'(32'h5C);
    localparam logic [CHAR_W-1:0] CH_T     = CHAR_W'(32'h74);
    localparam logic [CHAR_W-1:0] CH_N     = CHAR_W'(32'h6E);
    localparam logic [CHAR_W-1:0] CH_R     = CHAR_W'(32'h72);

    // Source of a character written into the field store
    typedef enum logic [2:0] {
        PS_IN,
        PS_BSL,
        PS_TAB,
        PS_LF,
        PS_CR
    } t_psel;

    // What the output register loads this cycle
    typedef enum logic [2:0] {
        EM_NONE,
        EM_QUOTE,
        EM_CHAR,
        EM_COMMA,
        EM_CR,
        EM_LF,
        EM_ERR
    } t_emit;

    // Controller to datapath commands
    typedef struct packed {
        logic  latch;
        logic  push;
        t_psel push_sel;
        logic  set_nq;
        logic  clr_nq;
        logic  set_pend;
        logic  clr_pend;
        logic  set_halt;
        logic  clr_fill;
        logic  clr_qno;
        logic  set_qno;
        logic  idx_clr;
        logic  idx_inc;
        t_emit emit;
        logic  emit_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_bsl;
        logic is_tnr;
        logic is_t;
        logic is_n;
        logic is_tab;
        logic is_term;
        logic is_special;
        logic pending;
        logic unesc;
        logic halted;
        logic nq;
        logic qno;
        logic fill_full_next;
        logic fill_zero;
        logic idx_last;
        logic cur_quote;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/tcq_if.sv @@
// Valid/ready channel interfaces: input characters, CSV output beats, configuration writes.
`default_nettype none

interface tcq_char_if import tcq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface tcq_csv_if import tcq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              bad_escape;

    modport source (output valid, output out_char, output run_last, output bad_escape,
                    input ready);
    modport sink (input valid, input out_char, input run_last, input bad_escape,
                  output ready);
endinterface

interface tcq_cfg_if;
    logic valid;
    logic ready;
    logic unescape_mode;

    modport source (output valid, output unescape_mode, input ready);
    modport sink (input valid, input unescape_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tcq_ctrl.sv @@
// Sequencing state machine of the field quoter: decode, store pushes, field emission.
`default_nettype none

module tcq_ctrl import tcq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_P1,
        S_P2,
        S_OPEN,
        S_CHAR,
        S_CLOSE,
        S_DELIM1,
        S_DELIM2,
        S_ERR
    } t_state;

    t_state r_state, n_state;
    t_psel  r_p1, n_p1;
    t_psel  r_p2, n_p2;
    logic   r_has_p2, n_has_p2;
    logic   r_term, n_term;
    logic   r_closing, n_closing;
    logic   r_from_p2, n_from_p2;
    logic   r_dbl, n_dbl;

    logic   close_q;

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign close_q    = r_closing && i_sts.nq;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_has_p2  = r_has_p2;
        n_term    = r_term;
        n_closing = r_closing;
        n_from_p2 = r_from_p2;
        n_dbl     = r_dbl;
        o_cmd     = '0;
        o_cmd.push_sel = PS_IN;
        o_cmd.emit     = EM_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_has_p2  = 1'b0;
                n_term    = 1'b0;
                n_closing = 1'b1;
                n_from_p2 = 1'b0;
                n_p1      = PS_IN;
                n_p2      = PS_IN;
                priority if (i_sts.halted) begin
                    n_state = S_IDLE;
                end else if (i_sts.is_bsl) begin
                    if (i_sts.pending) begin
                        // backslash pair: one or two backslashes
                        n_p1           = PS_BSL;
                        n_p2           = PS_BSL;
                        n_has_p2       = !i_sts.unesc;
                        o_cmd.clr_pend = 1'b1;
                        n_state        = S_P1;
                    end else begin
                        o_cmd.set_pend = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.is_tnr && i_sts.pending) begin
                    o_cmd.clr_pend = 1'b1;
                    n_state        = S_P1;
                    if (i_sts.unesc) begin
                        n_p1 = i_sts.is_t ? PS_TAB : (i_sts.is_n ? PS_LF : PS_CR);
                        o_cmd.set_nq = !i_sts.is_t;
                    end else begin
                        n_p1     = PS_BSL;
                        n_p2     = PS_IN;
                        n_has_p2 = 1'b1;
                    end
                end else if (i_sts.pending && i_sts.unesc) begin
                    // stray backslash while decoding
                    o_cmd.clr_pend = 1'b1;
                    n_state        = S_ERR;
                end else begin
                    o_cmd.clr_pend = 1'b1;
                    if (i_sts.is_term) begin
                        n_term  = 1'b1;
                        n_p1    = PS_BSL;
                        n_state = i_sts.pending ? S_P1 : S_OPEN;
                    end else begin
                        o_cmd.set_nq = i_sts.is_special;
                        n_state      = S_P1;
                        if (i_sts.pending) begin
                            n_p1     = PS_BSL;
                            n_p2     = PS_IN;
                            n_has_p2 = 1'b1;
                        end else begin
                            n_p1 = PS_IN;
                        end
                    end
                end
            end

            S_P1: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = r_p1;
                priority if (i_sts.fill_full_next) begin
                    o_cmd.set_nq = 1'b1;
                    n_closing    = 1'b0;
                    n_from_p2    = 1'b0;
                    n_state      = S_OPEN;
                end else if (r_has_p2) begin
                    n_state = S_P2;
                end else if (r_term) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_P2: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = r_p2;
                if (i_sts.fill_full_next) begin
                    o_cmd.set_nq = 1'b1;
                    n_closing    = 1'b0;
                    n_from_p2    = 1'b1;
                    n_state      = S_OPEN;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // opening quote, if the field is quoted and it has not gone out yet
            S_OPEN: begin
                o_cmd.idx_clr = 1'b1;
                n_dbl         = 1'b0;
                if (i_sts.nq && i_sts.qno) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = EM_QUOTE;
                        n_state    = i_sts.fill_zero ? S_CLOSE : S_CHAR;
                    end
                end else begin
                    n_state = i_sts.fill_zero ? S_CLOSE : S_CHAR;
                end
            end

            // stored characters, doubling quotes in a quoted field
            S_CHAR: begin
                if (i_sts.out_free) begin
                    if (i_sts.nq && i_sts.cur_quote && !r_dbl) begin
                        o_cmd.emit = EM_QUOTE;
                        n_dbl      = 1'b1;
                    end else begin
                        o_cmd.emit      = EM_CHAR;
                        o_cmd.emit_last = i_sts.idx_last && !r_closing && !r_term;
                        o_cmd.idx_inc   = 1'b1;
                        n_dbl           = 1'b0;
                        if (i_sts.idx_last) begin
                            n_state = S_CLOSE;
                        end
                    end
                end
            end

            // closing quote, if due, then drop the buffered field
            S_CLOSE: begin
                if (!close_q || i_sts.out_free) begin
                    if (close_q) begin
                        o_cmd.emit = EM_QUOTE;
                    end
                    o_cmd.clr_fill = 1'b1;
                    if (r_closing) begin
                        n_state = S_DELIM1;
                    end else begin
                        o_cmd.clr_qno = 1'b1;
                        priority if (r_from_p2) begin
                            n_state = S_IDLE;
                        end else if (r_has_p2) begin
                            n_state = S_P2;
                        end else if (r_term) begin
                            n_closing = 1'b1;
                            n_state   = S_OPEN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_DELIM1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_last = i_sts.is_tab;
                    if (i_sts.is_tab) begin
                        o_cmd.emit    = EM_COMMA;
                        o_cmd.set_qno = 1'b1;
                        o_cmd.clr_nq  = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.emit = EM_CR;
                        n_state    = S_DELIM2;
                    end
                end
            end

            S_DELIM2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = EM_LF;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.set_qno   = 1'b1;
                    o_cmd.clr_nq    = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = EM_ERR;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.set_halt  = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and plan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p1      <= PS_IN;
            r_p2      <= PS_IN;
            r_has_p2  <= 1'b0;
            r_term    <= 1'b0;
            r_closing <= 1'b1;
            r_from_p2 <= 1'b0;
            r_dbl     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_has_p2  <= n_has_p2;
            r_term    <= n_term;
            r_closing <= n_closing;
            r_from_p2 <= n_from_p2;
            r_dbl     <= n_dbl;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tcq_datapath.sv @@
// Field store, quoting flags, escape state and output register of the field quoter.
`default_nettype none
`include "tsv_to_csv_field_quoter_core_macros.svh"

module tcq_datapath import tcq_pkg::*; #(
    parameter int unsigned FIELD_BUF = FIELD_BUF_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_cfg_we,
    input  logic              i_cfg_unesc,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    output logic              o_out_bad
);

    localparam int unsigned IW = (FIELD_BUF > 1) ? $clog2(FIELD_BUF) : 1;
    localparam int unsigned CW = $clog2(FIELD_BUF + 1);

    logic [CHAR_W-1:0] r_store [FIELD_BUF];
    logic [CHAR_W-1:0] r_char;
    logic [CW-1:0]     r_fill;
    logic [IW-1:0]     r_idx;
    logic              r_unesc;
    logic              r_nq;
    logic              r_qno;
    logic              r_pend;
    logic              r_halt;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_ochar;
    logic              r_olast;
    logic              r_obad;

    logic [CHAR_W-1:0] push_val;
    logic [CHAR_W-1:0] cur;
    logic [CHAR_W-1:0] n_ochar;
    logic              out_free;

    assign cur      = r_store[r_idx];
    assign out_free = !r_ovalid || i_out_ready;

    // Select the character written into the store
    always_comb begin
        unique case (i_cmd.push_sel)
            PS_IN:   push_val = r_char;
            PS_BSL:  push_val = CH_BSL;
            PS_TAB:  push_val = CH_TAB;
            PS_LF:   push_val = CH_LF;
            PS_CR:   push_val = CH_CR;
            default: push_val = r_char;
        endcase
    end

    // Select the next output character
    always_comb begin
        unique case (i_cmd.emit)
            EM_QUOTE: n_ochar = CH_QUOTE;
            EM_CHAR:  n_ochar = cur;
            EM_COMMA: n_ochar = CH_COMMA;
            EM_CR:    n_ochar = CH_CR;
            EM_LF:    n_ochar = CH_LF;
            EM_ERR:   n_ochar = '0;
            default:  n_ochar = '0;
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_sts.is_bsl         = (r_char == CH_BSL);
        o_sts.is_t           = (r_char == CH_T);
        o_sts.is_n           = (r_char == CH_N);
        o_sts.is_tnr         = (r_char == CH_T) || (r_char == CH_N) || (r_char == CH_R);
        o_sts.is_tab         = (r_char == CH_TAB);
        o_sts.is_term        = (r_char == CH_TAB) || (r_char == CH_LF);
        o_sts.is_special     = (r_char == CH_QUOTE) || (r_char == CH_COMMA)
                               || (r_char == CH_CR);
        o_sts.pending        = r_pend;
        o_sts.unesc          = r_unesc;
        o_sts.halted         = r_halt;
        o_sts.nq             = r_nq;
        o_sts.qno            = r_qno;
        o_sts.fill_full_next = (r_fill == CW'(FIELD_BUF - 1));
        o_sts.fill_zero      = (r_fill == '0);
        o_sts.idx_last       = ((CW'(r_idx) + CW'(1)) == r_fill);
        o_sts.cur_quote      = (cur == CH_QUOTE);
        o_sts.out_free       = out_free;
    end

    // Write the field store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_store[r_fill[IW-1:0]] <= push_val;
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char <= i_in_char;
        end
    end

    // Advance counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unesc <= 1'b0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_nq    <= 1'b0;
            r_qno   <= 1'b1;
            r_pend  <= 1'b0;
            r_halt  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unesc <= i_cfg_unesc;
            end
            if (i_cmd.clr_fill) begin
                r_fill <= '0;
            end else if (i_cmd.push) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.set_nq) begin
                r_nq <= 1'b1;
            end else if (i_cmd.clr_nq) begin
                r_nq <= 1'b0;
            end
            if (i_cmd.clr_qno) begin
                r_qno <= 1'b0;
            end else if (i_cmd.set_qno) begin
                r_qno <= 1'b1;
            end
            if (i_cmd.set_pend) begin
                r_pend <= 1'b1;
            end else if (i_cmd.clr_pend) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.set_halt) begin
                r_halt <= 1'b1;
            end
        end
    end

    // Hold the output beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EM_NONE) begin
            r_ochar <= n_ochar;
            r_olast <= i_cmd.emit_last;
            r_obad  <= (i_cmd.emit == EM_ERR);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;
    assign o_out_bad   = r_obad;

    `TCQ_ASSERT_NOW(a_fill_range, 1'b1, r_fill <= CW'(FIELD_BUF), "fill count beyond store depth")
    `TCQ_ASSERT_NOW(a_push_room, i_cmd.push, r_fill < CW'(FIELD_BUF), "push into a full store")
    `TCQ_ASSERT_NOW(a_emit_free, i_cmd.emit != EM_NONE, out_free, "beat overwrites a waiting beat")
    `TCQ_ASSERT_NOW(a_halt_quiet, r_halt, i_cmd.emit == EM_NONE, "beat produced while halted")
    `TCQ_ASSERT_NEXT(a_err_halts, i_cmd.emit == EM_ERR, r_halt, "error beat did not halt")

endmodule

`default_nettype wire

@@ hw/rtl/tsv_to_csv_field_quoter_core.sv @@
// Top level of the TSV to CSV field quoter: controller, datapath and channel wiring.
//
// Takes one character per input beat and writes CSV characters, one per output beat; the last
// beat caused by an input carries run_last. An input that only buffers a character or marks a
// pending backslash is accepted, decoded, then pushes each character it writes to the store.
// Ending a field (tab or newline) runs through sequencing states and emits the beats: optional
// opening quote, each stored character, one extra beat per doubled quote, optional closing
// quote, then the comma or CR LF. A full store (FIELD_BUF characters) is flushed early as a
// quoted field, with no closing quote and no delimiter. Output beats leave through a single
// output register, one per cycle when the sink is ready; the controller walks the store one
// entry per cycle while the output register is free and no quote is doubled. Inputs are taken
// one at a time, only while the controller is idle. A stray backslash in unescape mode gives
// one beat with bad_escape set and the block then drops all input until reset. The
// configuration channel is ready whenever reset is released. No clearing pass after reset.
`default_nettype none

module tsv_to_csv_field_quoter_core import tcq_pkg::*; #(
    parameter int unsigned FIELD_BUF = FIELD_BUF_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcq_char_if.sink   i_char,
    tcq_csv_if.source  o_csv,
    tcq_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_char.ready = in_ready;
    assign i_cfg.ready  = i_rst_n;

    tcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcq_datapath #(
        .FIELD_BUF (FIELD_BUF)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_char   (i_char.in_char),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_unesc (i_cfg.unescape_mode),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_csv.ready),
        .o_out_valid (o_csv.valid),
        .o_out_char  (o_csv.out_char),
        .o_out_last  (o_csv.run_last),
        .o_out_bad   (o_csv.bad_escape)
    );

endmodule

`default_nettype wire

@@ test/tsv_to_csv_field_quoter_core_tb.sv @@
// Self-checking testbench for the TSV to CSV field quoter core.
`default_nettype none

module tsv_to_csv_field_quoter_core_tb;
    import tcq_pkg::*;

    localparam int unsigned FIELD_BUF     = FIELD_BUF_DEF;
    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned SETTLE_CYCLES = 2 * FIELD_BUF + 16;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned LIMIT_CYCLES  = 2_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } t_csv_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcq_char_if char_if ();
    tcq_csv_if  csv_if ();
    tcq_cfg_if  cfg_if ();

    tsv_to_csv_field_quoter_core #(
        .FIELD_BUF (FIELD_BUF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_csv   (csv_if),
        .i_cfg   (cfg_if)
    );

    // Predicted quoter state
    logic [CHAR_W-1:0] fld_chars [FIELD_BUF];
    int unsigned       fld_len;
    bit                fld_quoted;
    bit                fld_open_pending;
    bit                bsl_pending;
    bit                quoter_halted;
    bit                unesc_mode;

    // Expected CSV beats, oldest first
    t_csv_beat         csv_expected [$];
    logic [CHAR_W-1:0] held_ch;
    bit                beat_held;

    int unsigned fail_count;
    int unsigned items_sent;
    bit          steady_src;
    bit          steady_sink;
    bit          hold_request;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Hold back one beat so the last one of an input can be flagged
    function automatic void add_beat(input logic [CHAR_W-1:0] ch);
        t_csv_beat b;
        if (beat_held) begin
            b.ch   = held_ch;
            b.last = 1'b0;
            b.err  = 1'b0;
            csv_expected.push_back(b);
        end
        held_ch   = ch;
        beat_held = 1'b1;
    endfunction

    // Emit the buffered characters, doubling quotes when the field is quoted
    function automatic void flush_field(input bit closing);
        if (fld_quoted && fld_open_pending) begin
            add_beat(CH_QUOTE);
        end
        for (int k = 0; k < fld_len; k++) begin
            if (fld_quoted && fld_chars[k] == CH_QUOTE) begin
                add_beat(CH_QUOTE);
            end
            add_beat(fld_chars[k]);
        end
        if (fld_quoted && closing) begin
            add_beat(CH_QUOTE);
        end
        fld_len = 0;
    endfunction

    // Buffer one character; a full store flushes early and forces quoting
    function automatic void store_char(input logic [CHAR_W-1:0] ch);
        fld_chars[fld_len] = ch;
        fld_len++;
        if (fld_len >= FIELD_BUF) begin
            fld_quoted = 1'b1;
            flush_field(1'b0);
            fld_open_pending = 1'b0;
        end
    endfunction

    // Work out the CSV beats caused by one accepted character
    function automatic void predict_csv(input logic [CHAR_W-1:0] c);
        t_csv_beat b;
        beat_held = 1'b0;
        if (quoter_halted) begin
            return;
        end
        if (c == CH_BSL) begin
            if (bsl_pending) begin
                if (!unesc_mode) begin
                    store_char(CH_BSL);
                end
                store_char(CH_BSL);
                bsl_pending = 1'b0;
            end else begin
                bsl_pending = 1'b1;
            end
        end else if ((c == CH_T || c == CH_N || c == CH_R) && bsl_pending) begin
            if (unesc_mode) begin
                if (c == CH_T) begin
                    store_char(CH_TAB);
                end else begin
                    fld_quoted = 1'b1;
                    store_char(c == CH_N ? CH_LF : CH_CR);
                end
            end else begin
                store_char(CH_BSL);
                store_char(c);
            end
            bsl_pending = 1'b0;
        end else begin
            // Stray backslash: fatal when decoding, literal otherwise
            if (bsl_pending && unesc_mode) begin
                b.ch   = '0;
                b.last = 1'b1;
                b.err  = 1'b1;
                csv_expected.push_back(b);
                quoter_halted = 1'b1;
                bsl_pending   = 1'b0;
                return;
            end
            if (bsl_pending) begin
                store_char(CH_BSL);
                bsl_pending = 1'b0;
            end
            if (c == CH_TAB || c == CH_LF) begin
                flush_field(1'b1);
                if (c == CH_TAB) begin
                    add_beat(CH_COMMA);
                end else begin
                    add_beat(CH_CR);
                    add_beat(CH_LF);
                end
                fld_open_pending = 1'b1;
                fld_quoted       = 1'b0;
            end else begin
                if (c == CH_QUOTE || c == CH_COMMA || c == CH_CR) begin
                    fld_quoted = 1'b1;
                end
                store_char(c);
            end
        end
        if (beat_held) begin
            b.ch   = held_ch;
            b.last = 1'b1;
            b.err  = 1'b0;
            csv_expected.push_back(b);
        end
    endfunction

    // Offer one character after an optional gap and hold it until taken
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int unsigned gap;
        gap = steady_src ? 0 : pick_gap();
        if (gap != 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid   <= 1'b1;
        char_if.in_char <= c;
        do @(posedge i_clk); while (!char_if.ready);
        predict_csv(c);
        items_sent++;
    endtask

    // Drop valid, wait for every expected beat, then let the block settle
    task automatic drain_results();
        char_if.valid <= 1'b0;
        while (csv_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_if.valid         <= 1'b1;
        cfg_if.unescape_mode <= mode;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        unesc_mode = mode;
    endtask

    // Backslash then a backslash or t, n, r; when not decoding also a printable character or a tab
    task automatic send_escape();
        int unsigned r;
        send_char(CH_BSL);
        r = $urandom_range(0, unesc_mode ? 3 : 5);
        case (r)
            0: send_char(CH_BSL);
            1: send_char(CH_T);
            2: send_char(CH_N);
            3: send_char(CH_R);
            4: send_char(CHAR_W'($urandom_range(32, 126)));
            default: send_char(CH_TAB);
        endcase
    endtask

    task automatic send_random_char();
        int unsigned       r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            c = CHAR_W'($urandom_range(32, 126));
            if (c == CH_BSL) begin
                send_escape();
            end else begin
                send_char(c);
            end
        end else if (r < 58) begin
            case ($urandom_range(0, 2))
                0: send_char(CH_QUOTE);
                1: send_char(CH_COMMA);
                default: send_char(CH_CR);
            endcase
        end else if (r < 70) begin
            send_escape();
        end else if (r < 82) begin
            // Full code range; a lone backslash would halt a decoding block
            c = CHAR_W'($urandom_range(0, 21'h1FFFFF));
            send_char(c == CH_BSL ? CH_QUOTE : c);
        end else if (r < 88) begin
            case ($urandom_range(0, 2))
                0: send_char(CH_T);
                1: send_char(CH_N);
                default: send_char(CH_R);
            endcase
        end else if (r < 94) begin
            send_char(CHAR_W'($urandom_range(0, 31)));
        end else if (!unesc_mode) begin
            send_char(CH_BSL);
        end else begin
            send_char(CHAR_W'($urandom_range(21'h110000, 21'h1FFFFF)));
        end
    endtask

    // One field: mostly short, now and then about as long as the store or longer
    task automatic send_random_field();
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
        repeat (len) send_random_char();
        send_char($urandom_range(0, 9) < 6 ? CH_TAB : CH_LF);
    endtask

    task automatic send_random_fields(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            send_random_field();
        end
    endtask

    // Empty first field, quote doubling, extreme code points, empty field at line end
    task automatic test_quoting();
        drain_results();
        write_mode(1'b0);
        send_char(CH_TAB);
        send_char(CH_QUOTE);
        send_char({CHAR_W{1'b1}});
        send_char('0);
        send_char(CH_TAB);
        send_char(CH_LF);
    endtask

    // Escapes kept as typed, stray backslash before a newline kept too
    task automatic test_kept_escapes();
        send_char(CH_COMMA);
        send_char(CH_BSL);
        send_char(CH_T);
        send_char(CH_BSL);
        send_char(CH_BSL);
        send_char(CH_BSL);
        send_char(CH_LF);
    endtask

    task automatic test_decoded_escapes();
        drain_results();
        write_mode(1'b1);
        send_char(CH_BSL);
        send_char(CH_N);
        send_char(CH_BSL);
        send_char(CH_R);
        send_char(CH_BSL);
        send_char(CH_T);
        send_char(CH_BSL);
        send_char(CH_BSL);
        send_char(CH_TAB);
    endtask

    // Fill the store exactly, then end the field with only the closing quote due
    task automatic test_store_full();
        send_char(CH_QUOTE);
        for (int k = 0; k < FIELD_BUF - 2; k++) begin
            send_char(CHAR_W'(8'h41 + k));
        end
        send_char(CH_QUOTE);
        send_char(CH_LF);
    endtask

    task automatic test_random_literal();
        drain_results();
        write_mode(1'b0);
        send_random_fields(80);
        send_char(CH_LF);
    endtask

    task automatic test_random_decoding();
        drain_results();
        write_mode(1'b1);
        send_random_fields(80);
    endtask

    // Hold off the output for a long stretch while input keeps coming
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        steady_src   = 1'b1;
        send_random_fields(40);
        steady_src = 1'b0;
        send_random_fields(60);
        send_char(CH_LF);
    endtask

    task automatic test_steady_stream();
        drain_results();
        write_mode(1'b0);
        steady_src  = 1'b1;
        steady_sink = 1'b1;
        send_random_fields(90);
        send_char(CH_LF);
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    // Stray backslash while decoding halts the block; later input is dropped, also after a mode write
    task automatic test_stray_escape_halt();
        drain_results();
        write_mode(1'b1);
        send_char(CHAR_W'(8'h61));
        send_char(CH_BSL);
        send_char(CHAR_W'(8'h78));
        send_char(CHAR_W'(8'h62));
        send_char(CH_LF);
        drain_results();
        write_mode(1'b0);
        send_char(CH_BSL);
        send_char(CHAR_W'(8'h79));
        send_char(CH_LF);
    endtask

    // Pace the output side; a hold request stalls it for a long stretch
    initial begin : csv_pacing
        int unsigned stall_left;
        stall_left = 0;
        csv_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady_sink) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                csv_if.ready <= 1'b0;
                stall_left--;
            end else begin
                csv_if.ready <= 1'b1;
            end
        end
    end

    // Check each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_csv_beat want;
        if (i_rst_n && csv_if.valid && csv_if.ready) begin
            if (csv_expected.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual char %h last %b err %b",
                         $time, csv_if.out_char, csv_if.run_last, csv_if.bad_escape);
                fail_count++;
            end else begin
                want = csv_expected.pop_front();
                if (csv_if.out_char !== want.ch) begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, want.ch, csv_if.out_char);
                    fail_count++;
                end
                if (csv_if.run_last !== want.last) begin
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, want.last, csv_if.run_last);
                    fail_count++;
                end
                if (csv_if.bad_escape !== want.err) begin
                    $display("%0t: bad_escape mismatch: expected %b, actual %b",
                             $time, want.err, csv_if.bad_escape);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : run_tests
        i_rst_n              <= 1'b0;
        char_if.valid        <= 1'b0;
        char_if.in_char      <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.unescape_mode <= 1'b0;
        fail_count       = 0;
        items_sent       = 0;
        steady_src       = 1'b0;
        steady_sink      = 1'b0;
        hold_request     = 1'b0;
        fld_len          = 0;
        fld_quoted       = 1'b0;
        fld_open_pending = 1'b1;
        bsl_pending      = 1'b0;
        quoter_halted    = 1'b0;
        unesc_mode       = 1'b0;
        beat_held        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_quoting();
        test_kept_escapes();
        test_decoded_escapes();
        test_store_full();
        test_random_literal();
        test_random_decoding();
        test_output_backpressure();
        test_steady_stream();
        test_stray_escape_halt();

        drain_results();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
